// File: src/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants for the LZSS stream decoder.
// ----------------------------------------------------------------------------
package lzsd_pkg;

	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam int COUNT_BITS_DEF   = 24;
	localparam int SIZE_W           = 24;
	localparam int OFF_W            = 12;
	localparam int LEN_W            = 4;
	localparam int REM_W            = 5;
	localparam int MIN_MATCH        = 3;
	localparam int CMD_DEPTH        = 4;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_TOK,
		PH_HI
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_TRUNC = 3'd1,
		ST_DIST  = 3'd2,
		ST_OVER  = 3'd3,
		ST_TRAIL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_STAT
	} cmd_op_t;

	typedef enum logic {
		B_IDLE,
		B_COPY
	} back_state_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [7:0]       data;
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic             fin;
		status_t          status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: src/lzsd_ram.sv
// ----------------------------------------------------------------------------
// lzsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/lzsd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lzsd_cmd_fifo
// Small command queue between the token parser and the output engine.
// ----------------------------------------------------------------------------
module lzsd_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lzsd_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output lzsd_pkg::cmd_t    head,
	output lzsd_pkg::q_stat_t qs
);
	import lzsd_pkg::*;

	localparam int PW = $clog2(CMD_DEPTH);

	cmd_t        mem_q [CMD_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assign head     = mem_q[rp_q];
	assign qs.full  = (cnt_q == (PW+1)'(CMD_DEPTH));
	assign qs.empty = (cnt_q == '0);

endmodule

// File: src/lzsd_front.sv
// ----------------------------------------------------------------------------
// lzsd_front
// Input side: flag/token parsing, size and distance checks, error swallowing.
// ----------------------------------------------------------------------------
module lzsd_front #(
	parameter int COUNT_BITS = lzsd_pkg::COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [lzsd_pkg::SIZE_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	output logic                      push,
	output lzsd_pkg::cmd_t            cmd,
	input  lzsd_pkg::q_stat_t         qs
);
	import lzsd_pkg::*;

	localparam int XW = 33;

	logic [SIZE_W-1:0]     size_q;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	phase_t                phase_q, phase_d;
	logic [7:0]            flag_q, flag_d;
	logic [2:0]            bit_q, bit_d;
	logic [7:0]            tok_q, tok_d;
	logic                  swallow_q, swallow_d;

	logic [XW-1:0] max_x, size_x, lim_x, cnt_x, dist_x, len_x, sum_x, lit_x, new_x;
	logic          acc, grew, err, fin;

	assign in_ready = !qs.full;
	assign acc      = in_valid && in_ready;

	assign max_x  = (XW'(1) << COUNT_BITS) - XW'(1);
	assign size_x = XW'(size_q);
	assign lim_x  = (size_x > max_x) ? max_x : size_x;
	assign cnt_x  = XW'(cnt_q);
	assign dist_x = XW'({in_byte[3:0], tok_q}) + XW'(1);
	assign len_x  = XW'(in_byte[7:4]) + XW'(MIN_MATCH);
	assign sum_x  = cnt_x + len_x;
	assign lit_x  = cnt_x + XW'(1);

	always_comb begin
		cnt_d     = cnt_q;
		phase_d   = phase_q;
		flag_d    = flag_q;
		bit_d     = bit_q;
		tok_d     = tok_q;
		swallow_d = swallow_q;
		push      = 1'b0;
		grew      = 1'b0;
		err       = 1'b0;
		fin       = 1'b0;
		new_x     = cnt_x;
		cmd.op     = CMD_STAT;
		cmd.data   = '0;
		cmd.off    = {in_byte[3:0], tok_q};
		cmd.len    = in_byte[7:4];
		cmd.fin    = 1'b0;
		cmd.status = ST_OK;
		if (acc) begin
			if (swallow_q) begin
				if (in_last) begin
					swallow_d = 1'b0;
					cnt_d     = '0;
					phase_d   = PH_FLAG;
				end
			end else if (cnt_x >= lim_x) begin
				push       = 1'b1;
				cmd.fin    = 1'b1;
				cmd.status = ST_TRAIL;
				fin        = 1'b1;
			end else begin
				case (phase_q)
					PH_FLAG: begin
						flag_d  = in_byte;
						bit_d   = '0;
						phase_d = PH_TOK;
					end
					PH_TOK: begin
						if (flag_q[bit_q]) begin
							tok_d   = in_byte;
							phase_d = PH_HI;
						end else begin
							push     = 1'b1;
							cmd.op   = CMD_LIT;
							cmd.data = in_byte;
							cnt_d    = COUNT_BITS'(lit_x);
							new_x    = lit_x;
							grew     = 1'b1;
							bit_d    = bit_q + 3'd1;
							phase_d  = (bit_q == 3'd7) ? PH_FLAG : PH_TOK;
						end
					end
					PH_HI: begin
						if (dist_x > cnt_x) begin
							push       = 1'b1;
							cmd.fin    = 1'b1;
							cmd.status = ST_DIST;
							fin        = 1'b1;
							err        = 1'b1;
						end else if (sum_x > lim_x) begin
							push       = 1'b1;
							cmd.fin    = 1'b1;
							cmd.status = ST_OVER;
							fin        = 1'b1;
							err        = 1'b1;
						end else begin
							push    = 1'b1;
							cmd.op  = CMD_COPY;
							cnt_d   = COUNT_BITS'(sum_x);
							new_x   = sum_x;
							grew    = 1'b1;
							bit_d   = bit_q + 3'd1;
							phase_d = (bit_q == 3'd7) ? PH_FLAG : PH_TOK;
						end
					end
					default: begin
						phase_d = PH_FLAG;
					end
				endcase
				if (!err) begin
					if (grew && new_x >= lim_x) begin
						cmd.fin    = 1'b1;
						cmd.status = in_last ? ST_OK : ST_TRAIL;
						fin        = 1'b1;
					end else if (in_last) begin
						push       = 1'b1;
						cmd.fin    = 1'b1;
						cmd.status = ST_TRUNC;
						fin        = 1'b1;
					end
				end
			end
			if (fin) begin
				if (in_last) begin
					swallow_d = 1'b0;
					cnt_d     = '0;
					phase_d   = PH_FLAG;
				end else begin
					swallow_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SIZE_W'(1);
			cnt_q     <= '0;
			phase_q   <= PH_FLAG;
			flag_q    <= '0;
			bit_q     <= '0;
			tok_q     <= '0;
			swallow_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			cnt_q     <= cnt_d;
			phase_q   <= phase_d;
			flag_q    <= flag_d;
			bit_q     <= bit_d;
			tok_q     <= tok_d;
			swallow_q <= swallow_d;
		end
	end

	// block always closes with a result on a live last byte
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !swallow_q && in_last |-> push && cmd.fin)
		else $error("last byte did not close block");

	a_swallow_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		swallow_q |-> !push)
		else $error("command pushed while swallowing");

endmodule

// File: src/lzsd_back.sv
// ----------------------------------------------------------------------------
// lzsd_back
// Output side: literal and match expansion through the history RAM.
// ----------------------------------------------------------------------------
module lzsd_back #(
	parameter int WINDOW_DEPTH = lzsd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lzsd_pkg::cmd_t    head,
	input  lzsd_pkg::q_stat_t qs,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              has_byte,
	output logic              out_last,
	output logic [2:0]        status
);
	import lzsd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	back_state_t      state_q, state_d;
	logic [REM_W-1:0] rem_q, rem_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic             fin_q, fin_d;
	status_t          cst_q, cst_d;
	logic [AW-1:0]    iptr_q;

	logic             valid_s1, ram_s1, has_s1, fin_s1, byp_s1;
	logic [7:0]       byte_s1, bypd_s1;
	status_t          stat_s1;
	logic [AW-1:0]    waddr_s1;

	logic             ovalid_q, ohas_q, olast_q;
	logic [7:0]       obyte_q;
	status_t          ostat_q;

	logic             slot_free, mv, can_issue, issue, is_copy;
	logic             n_has, n_fin;
	logic [7:0]       n_byte, s1_byte, rdata;
	status_t          n_stat;
	logic [OFF_W-1:0] cur_off;
	logic [AW-1:0]    raddr;

	assign slot_free = !ovalid_q || out_ready;
	assign mv        = valid_s1 && slot_free;
	assign can_issue = !valid_s1 || mv;
	assign s1_byte   = ram_s1 ? (byp_s1 ? bypd_s1 : rdata) : byte_s1;
	assign cur_off   = (state_q == B_IDLE) ? head.off : off_q;
	assign raddr     = iptr_q - AW'(cur_off) - AW'(1);

	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		off_d   = off_q;
		fin_d   = fin_q;
		cst_d   = cst_q;
		pop     = 1'b0;
		issue   = 1'b0;
		is_copy = 1'b0;
		n_has   = 1'b0;
		n_byte  = '0;
		n_fin   = 1'b0;
		n_stat  = ST_OK;
		case (state_q)
			B_IDLE: begin
				if (!qs.empty && can_issue) begin
					pop   = 1'b1;
					issue = 1'b1;
					case (head.op)
						CMD_COPY: begin
							is_copy = 1'b1;
							n_has   = 1'b1;
							rem_d   = REM_W'(head.len) + REM_W'(MIN_MATCH - 1);
							off_d   = head.off;
							fin_d   = head.fin;
							cst_d   = head.status;
							state_d = B_COPY;
						end
						CMD_LIT: begin
							n_has  = 1'b1;
							n_byte = head.data;
							n_fin  = head.fin;
							n_stat = head.status;
						end
						default: begin
							n_fin  = head.fin;
							n_stat = head.status;
						end
					endcase
				end
			end
			B_COPY: begin
				if (can_issue) begin
					issue   = 1'b1;
					is_copy = 1'b1;
					n_has   = 1'b1;
					rem_d   = rem_q - REM_W'(1);
					if (rem_q == REM_W'(1)) begin
						n_fin   = fin_q;
						n_stat  = cst_q;
						state_d = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	lzsd_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (mv && has_s1),
		.waddr (waddr_s1),
		.wdata (s1_byte),
		.re    (issue && is_copy),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (issue) begin
			ram_s1   <= is_copy;
			has_s1   <= n_has;
			byte_s1  <= n_byte;
			fin_s1   <= n_fin;
			stat_s1  <= n_stat;
			waddr_s1 <= iptr_q;
			byp_s1   <= mv && has_s1 && (waddr_s1 == raddr);
			bypd_s1  <= s1_byte;
		end
		if (mv) begin
			obyte_q <= s1_byte;
			ohas_q  <= has_s1;
			olast_q <= fin_s1;
			ostat_q <= stat_s1;
		end
		off_q <= off_d;
		fin_q <= fin_d;
		cst_q <= cst_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			rem_q    <= '0;
			iptr_q   <= '0;
			valid_s1 <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			if (issue && n_has) begin
				iptr_q <= iptr_q + AW'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (mv) begin
				valid_s1 <= 1'b0;
			end
			if (mv) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_byte  = obyte_q;
	assign has_byte  = ohas_q;
	assign out_last  = olast_q;
	assign status    = ostat_q;

	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !olast_q |-> ostat_q == ST_OK)
		else $error("status on non-final transaction");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !ohas_q |-> olast_q)
		else $error("byteless transaction not final");

	a_copy_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_COPY |-> rem_q != '0)
		else $error("copy state with nothing left");

endmodule

// File: src/lzss_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder_core
// LZSS decoder, 12-bit distance / 4-bit length, 4 KiB history window.
// ----------------------------------------------------------------------------
//  channel | signals                                  | flow
//  --------+------------------------------------------+-----------------------
//  in      | in_valid/in_ready, in_byte, in_last      | one encoded byte
//  out     | out_valid/out_ready, out_byte, has_byte, | one decoded byte or
//          | out_last, status                         | end-of-block status
//  cfg     | cfg_wr_en, cfg_wr_data                   | decoded_size write
//
//  Input accepts one byte per cycle while the 4-entry command queue has room.
//  Output gives one transaction per cycle while out_ready allows; a match of
//  length L occupies the output engine for L single-port history RAM reads.
//  History RAM is not cleared at reset; reset clears only control state.
//  A stalled output fills the queue and then drops in_ready.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_core #(
	parameter int WINDOW_DEPTH = lzsd_pkg::WINDOW_DEPTH_DEF,
	parameter int COUNT_BITS   = lzsd_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lzsd_pkg::SIZE_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	input  logic                        in_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        has_byte,
	output logic                        out_last,
	output logic [2:0]                  status
);
	import lzsd_pkg::*;

	logic    push, pop;
	cmd_t    cmd, head;
	q_stat_t qs;

	lzsd_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.push        (push),
		.cmd         (cmd),
		.qs          (qs)
	);

	lzsd_cmd_fifo u_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.qs       (qs)
	);

	lzsd_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qs        (qs),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last),
		.status    (status)
	);

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lzss_stream_decoder_core. Encoded blocks (well
// formed, truncated, with trailing bytes, with bad distances, overruns and
// plain noise) are queued for a random-gap driver. Every accepted byte runs
// through a local decoder that queues the expected output transactions; a
// random-stall monitor checks each output transaction against that queue.
// ----------------------------------------------------------------------------
module tb;
	import lzsd_pkg::*;

	localparam int WIN       = 4096;
	localparam int DRAIN     = 64;
	localparam int HOLD_LEN  = 400;
	localparam int unsigned LIMIT = 600000;
	localparam int MAX_SIZE  = 24'hFFFFFF;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
		status_t    st;
	} dec_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} enc_item_t;

	typedef enum int {
		BK_GOOD,
		BK_TRUNC,
		BK_TRAIL,
		BK_DIST,
		BK_OVER,
		BK_OPEN,
		BK_NOISE
	} blk_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [SIZE_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        in_byte = 8'h00;
	logic              in_last = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        out_byte;
	logic              has_byte;
	logic              out_last;
	logic [2:0]        status;

	lzss_stream_decoder_core #(
		.WINDOW_DEPTH(WINDOW_DEPTH_DEF),
		.COUNT_BITS(COUNT_BITS_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.out_last(out_last),
		.status(status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// decoder state mirror
	logic [7:0]        hist [0:WIN-1];
	logic [SIZE_W-1:0] n_out;
	logic [SIZE_W-1:0] size_reg = 24'd1;
	logic [7:0]        flags;
	logic [7:0]        tok_lo;
	logic [3:0]        bit_no;
	phase_t            ph;
	logic              swallow = 1'b0;

	dec_res_t  dec_out_q[$];
	dec_res_t  step_q[$];
	enc_item_t enc_in_q[$];
	enc_item_t blk_q[$];

	int bad = 0;
	bit idle_on = 1'b1;
	int hold_ticket = 0;

	task automatic restart_block();
		n_out  = '0;
		flags  = 8'h00;
		bit_no = 4'd8;
		ph     = PH_FLAG;
		tok_lo = 8'h00;
	endtask

	task automatic emit_dec(input logic [7:0] b);
		dec_res_t r;
		hist[n_out[11:0]] = b;
		n_out = n_out + 1'b1;
		r = '{data: b, has: 1'b1, last: 1'b0, st: ST_OK};
		step_q.push_back(r);
	endtask

	task automatic end_block(input status_t s, input logic last);
		dec_res_t r;
		if (step_q.size() == 0) begin
			r = '{data: 8'h00, has: 1'b0, last: 1'b0, st: ST_OK};
			step_q.push_back(r);
		end
		r = step_q[step_q.size()-1];
		r.last = 1'b1;
		r.st = s;
		step_q[step_q.size()-1] = r;
		if (last) begin
			swallow = 1'b0;
			restart_block();
		end else begin
			swallow = 1'b1;
		end
	endtask

	task automatic next_bit();
		bit_no = bit_no + 1'b1;
		ph = (bit_no >= 4'd8) ? PH_FLAG : PH_TOK;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		int unsigned back_dist;
		int unsigned len;
		int unsigned i;
		logic [15:0] tok;
		logic [11:0] idx;
		bit done;
		step_q.delete();
		done = 1'b0;
		if (swallow) begin
			if (last) begin
				swallow = 1'b0;
				restart_block();
			end
			done = 1'b1;
		end else if (n_out >= size_reg) begin
			end_block(ST_TRAIL, last);
			done = 1'b1;
		end else begin
			case (ph)
				PH_FLAG: begin
					flags = b;
					bit_no = 4'd0;
					ph = PH_TOK;
				end
				PH_TOK: begin
					if (flags[bit_no[2:0]]) begin
						tok_lo = b;
						ph = PH_HI;
					end else begin
						emit_dec(b);
						next_bit();
					end
				end
				default: begin
					tok = {b, tok_lo};
					back_dist = int'(tok[11:0]) + 1;
					len = int'(tok[15:12]) + MIN_MATCH;
					if (back_dist > n_out) begin
						end_block(ST_DIST, last);
						done = 1'b1;
					end else if (int'(n_out) + len > int'(size_reg)) begin
						end_block(ST_OVER, last);
						done = 1'b1;
					end else begin
						for (i = 0; i < len; i++) begin
							idx = n_out[11:0] - back_dist[11:0];
							emit_dec(hist[idx]);
						end
						next_bit();
					end
				end
			endcase
			if (!done) begin
				if (n_out >= size_reg)
					end_block(last ? ST_OK : ST_TRAIL, last);
				else if (last)
					end_block(ST_TRUNC, last);
			end
		end
		foreach (step_q[j])
			dec_out_q.push_back(step_q[j]);
	endtask

	// driver
	int in_gap = 0;
	int in_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		enc_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= 8'h00;
			in_last  <= 1'b0;
		end else begin
			if (!in_valid || in_ready) begin
				if (in_valid)
					decode_byte(in_byte, in_last);
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (enc_in_q.size() != 0 && idle_on && in_calm == 0 &&
				             $urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 15) == 0)
						in_calm = $urandom_range(50, 200);
					in_gap = $urandom_range(0, 18);
					in_valid <= 1'b0;
				end else if (enc_in_q.size() != 0) begin
					it = enc_in_q.pop_front();
					in_byte  <= it.b;
					in_last  <= it.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (in_calm > 0)
				in_calm--;
		end
	end

	// monitor
	int out_gap = 0;
	int out_calm = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		dec_res_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (dec_out_q.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("ERROR: unexpected transaction byte=%h has=%b last=%b status=%0d",
						         out_byte, has_byte, out_last, status);
				end else begin
					w = dec_out_q.pop_front();
					if (out_byte !== w.data || has_byte !== w.has ||
					    out_last !== w.last || status !== w.st) begin
						bad++;
						if (bad <= 10)
							$display("ERROR: exp byte=%h has=%b last=%b status=%0d, got byte=%h has=%b last=%b status=%0d",
							         w.data, w.has, w.last, w.st,
							         out_byte, has_byte, out_last, status);
					end
				end
			end
			if (hold_seen != hold_ticket) begin
				hold_seen = hold_ticket;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (idle_on && out_calm == 0 && $urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 15) == 0) begin
					out_calm = $urandom_range(50, 200);
					out_ready <= 1'b1;
				end else begin
					out_gap = $urandom_range(0, 18);
					out_ready <= 1'b0;
				end
			end else begin
				out_ready <= 1'b1;
			end
			if (out_calm > 0)
				out_calm--;
		end
	end

	// watchdog
	int unsigned cyc = 0;

	initial begin
		while (cyc < LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Mismatches found");
		$finish;
	end

	function automatic int imin(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	task automatic push_item(input logic [7:0] b, input logic last);
		enc_item_t it;
		it = '{b: b, last: last};
		enc_in_q.push_back(it);
	endtask

	task automatic wait_idle();
		while (!(enc_in_q.size() == 0 && !in_valid && dec_out_q.size() == 0))
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_size(input logic [SIZE_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		size_reg = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_last_at(input int k, input logic last);
		enc_item_t t;
		t = blk_q[k];
		t.last = last;
		blk_q[k] = t;
	endtask

	task automatic push_match(input int mdist, input int len);
		logic [15:0] tok;
		tok = {4'(len - MIN_MATCH), 12'(mdist - 1)};
		blk_q.push_back('{b: tok[7:0], last: 1'b0});
		blk_q.push_back('{b: tok[15:8], last: 1'b0});
	endtask

	// builds one encoded block aimed at a decoded size of n (for noise, n+1 random bytes) and queues it
	task automatic gen_block(input int n, input blk_kind_t kind, input int match_pct);
		int p;
		int pos;
		int bitn;
		int room;
		int len;
		int mdist;
		int cut;
		logic [7:0] fl;
		enc_item_t t;
		bit done;
		bit err;
		blk_q.delete();
		p = 0;
		done = 1'b0;
		err = 1'b0;
		if (kind == BK_NOISE) begin
			repeat (n) blk_q.push_back('{b: 8'($urandom()), last: ($urandom_range(0, 4) == 0)});
			blk_q.push_back('{b: 8'($urandom()), last: 1'b1});
		end else begin
			while (!done) begin
				pos = blk_q.size();
				blk_q.push_back('{b: 8'h00, last: 1'b0});
				fl = 8'($urandom());
				for (bitn = 0; bitn < 8 && !done; bitn++) begin
					room = n - p;
					if (kind == BK_DIST && p < WIN && $urandom_range(0, 3) == 0) begin
						fl[bitn] = 1'b1;
						push_match($urandom_range(p + 1, imin(p + 40, WIN)), $urandom_range(3, 18));
						done = 1'b1;
						err = 1'b1;
					end else if (kind == BK_OVER && p >= 1 && room <= 17) begin
						fl[bitn] = 1'b1;
						push_match($urandom_range(1, imin(p, WIN)), $urandom_range(room + 1, 18));
						done = 1'b1;
						err = 1'b1;
					end else if (p >= 1 && room >= 3 && $urandom_range(0, 99) < match_pct) begin
						fl[bitn] = 1'b1;
						len = $urandom_range(3, imin(room, 18));
						if ($urandom_range(0, 7) == 0)
							mdist = imin(p, WIN);
						else
							mdist = $urandom_range(1, imin(p, WIN));
						push_match(mdist, len);
						p += len;
					end else begin
						fl[bitn] = 1'b0;
						blk_q.push_back('{b: 8'($urandom()), last: 1'b0});
						p++;
					end
					if (p >= n)
						done = 1'b1;
				end
				t = blk_q[pos];
				t.b = fl;
				blk_q[pos] = t;
			end
			if (err || kind == BK_TRAIL) begin
				if (kind == BK_TRAIL || $urandom_range(0, 1) == 0)
					repeat ($urandom_range(1, 4)) blk_q.push_back('{b: 8'($urandom()), last: 1'b0});
				set_last_at(blk_q.size() - 1, 1'b1);
			end else if (kind == BK_TRUNC || kind == BK_OPEN) begin
				cut = (kind == BK_OPEN) ? $urandom_range(blk_q.size() / 2, blk_q.size() - 2)
				                        : $urandom_range(0, blk_q.size() - 2);
				while (blk_q.size() > cut + 1)
					void'(blk_q.pop_back());
				set_last_at(blk_q.size() - 1, kind == BK_TRUNC);
			end else begin
				set_last_at(blk_q.size() - 1, 1'b1);
			end
		end
		foreach (blk_q[j])
			enc_in_q.push_back(blk_q[j]);
	endtask

	initial begin
		int rand_items;
		int iter;
		int sz;
		int r;
		int spin;
		blk_kind_t kind;

		for (int i = 0; i < WIN; i++)
			hist[i] = 8'h00;
		restart_block();
		rand_items = 0;
		iter = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// size 1 after reset: single literal, then truncation on a flag byte
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(8'hFF, 1'b1);

		set_size(24'd4);
		// distance past the start, then swallow to the mark
		push_item(8'h01, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h55, 1'b1);
		// literal plus overlapping copy, completes on the mark
		push_item(8'h02, 1'b0);
		push_item(8'hA5, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b1);
		// copy overruns the size, on the mark
		push_item(8'h02, 1'b0);
		push_item(8'h11, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h10, 1'b1);
		// completes before the mark: trailing input
		push_item(8'h00, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(8'h7F, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'hFE, 1'b0);
		push_item(8'h33, 1'b1);

		set_size(24'(MAX_SIZE));
		// longest copy, block cut short
		push_item(8'hFE, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hF0, 1'b1);

		while (rand_items < 140) begin
			if (iter == 1) begin
				// output held off while the input keeps coming
				set_size(24'd300);
				hold_ticket++;
				gen_block(300, BK_GOOD, 50);
				rand_items += blk_q.size();
			end else if (iter == 3) begin
				set_size(24'(MAX_SIZE));
				repeat (3) begin
					gen_block($urandom_range(5, 40), BK_GOOD, 50);
					rand_items += blk_q.size();
				end
			end else if (iter == 5) begin
				// size lowered while a block is open
				sz = $urandom_range(10, 40);
				set_size(24'(sz));
				gen_block(sz, BK_OPEN, 50);
				wait_idle();
				if (n_out >= 1)
					set_size(24'($urandom_range(1, int'(n_out))));
				gen_block(3, BK_NOISE, 0);
			end else begin
				r = $urandom_range(0, 9);
				sz = (r < 7) ? $urandom_range(1, 40) : $urandom_range(41, 300);
				set_size(24'(sz));
				repeat ($urandom_range(2, 5)) begin
					r = $urandom_range(0, 19);
					if (r < 9)       kind = BK_GOOD;
					else if (r < 12) kind = BK_TRUNC;
					else if (r < 15) kind = BK_TRAIL;
					else if (r < 17) kind = BK_DIST;
					else if (r < 19) kind = BK_OVER;
					else             kind = BK_NOISE;
					gen_block((kind == BK_NOISE) ? $urandom_range(1, 8) : sz, kind, 50);
					rand_items += blk_q.size();
				end
			end
			iter++;
		end

		// steady stream at the end, no idling
		set_size(24'($urandom_range(20, 60)));
		idle_on = 1'b0;
		repeat (3) begin
			gen_block(int'(size_reg), BK_GOOD, 50);
		end

		while (enc_in_q.size() != 0 || in_valid)
			@(posedge clk);
		spin = 0;
		while (dec_out_q.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		repeat (DRAIN) @(posedge clk);
		if (dec_out_q.size() != 0) begin
			$display("ERROR: %0d expected transactions never arrived", dec_out_q.size());
			bad += dec_out_q.size();
		end

		if (bad == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
